@@ hw/rtl/u2ra_pkg.sv @@
// ----------------------------------------------------------------------------
// u2ra_pkg
// shared types, widths and constants for the radix ascii converter
// ----------------------------------------------------------------------------
package u2ra_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned DIGIT_W        = 6;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned IN_TDATA_W     = 72;
  localparam int unsigned OUT_TDATA_W    = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT   = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = CHAR_W'(65);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_SEND
  } u2ra_state_e;

  // load: take a fresh dividend and divisor and start
  // next: divide the current quotient again
  typedef struct packed {
    logic load;
    logic next;
  } div_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d < DIGIT_LIMIT) begin
      return dw + CHAR_ZERO;
    end
    return dw - CHAR_W'(DIGIT_LIMIT) + CHAR_LETTER_A;
  endfunction

endpackage

@@ hw/rtl/u2ra_divider.sv @@
// ----------------------------------------------------------------------------
// u2ra_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module u2ra_divider
  import u2ra_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [DIGIT_W-1:0]    remainder_o
);

  localparam int unsigned SW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [SW-1:0]         step_q, step_d;
  logic [VALUE_BITS-1:0] dvd_q, dvd_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    dsr_q, dsr_d;
  logic [DIGIT_W:0]      trial;
  logic                  fits;

  assign trial = {rem_q, dvd_q[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (ctrl_i.load || ctrl_i.next) begin
      busy_d = 1'b1;
      step_d = SW'(VALUE_BITS - 1);
      rem_d  = '0;
      if (ctrl_i.load) begin
        dvd_d = dividend_i;
        dsr_d = divisor_i;
      end
    end else if (busy_q) begin
      dvd_d = {dvd_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? DIGIT_W'(trial - {1'b0, dsr_q}) : DIGIT_W'(trial);
      step_d = step_q - SW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

@@ hw/rtl/u2ra_digit_stack.sv @@
// ----------------------------------------------------------------------------
// u2ra_digit_stack
// digit memory, written least significant digit first, read back in reverse
// ----------------------------------------------------------------------------
module u2ra_digit_stack
  import u2ra_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(VALUE_BITS)-1:0] wr_addr_i,
  input  logic [DIGIT_W-1:0]            wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(VALUE_BITS)-1:0] rd_addr_i,
  output logic [DIGIT_W-1:0]            rd_data_o
);

  logic [DIGIT_W-1:0] mem_q [VALUE_BITS];
  logic [DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/unsigned_to_radix_ascii.sv @@
// ----------------------------------------------------------------------------
// unsigned_to_radix_ascii
// converts an unsigned value to ascii digits in base 2 to 36, most
// significant digit first, one output transaction per digit
// ----------------------------------------------------------------------------
// Takes one value and base per input transaction and returns its digits as
// ascii '0'-'9' then 'A'-'Z', tlast on the final digit. Only the low
// VALUE_BITS bits of the value are used; zero gives the single digit '0'.
// A base outside 2..36 gives one transaction with tuser set, tlast set and
// data zero. Digits come from a bit-serial divider and are read back from
// the digit memory in reverse order; the input is not ready until the last
// digit of an item has been sent.
module unsigned_to_radix_ascii
  import u2ra_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [63:0] number_value, [69:64] radix, [71:70] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [6:0] digit_char, [7] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o,
  // [0] bad_radix
  output logic                   m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(VALUE_BITS);
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);

  u2ra_state_e           state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  bad_q, bad_d;
  logic                  last_q, last_d;
  div_ctrl_t             div_ctrl;
  logic                  div_done;
  logic [VALUE_BITS-1:0] quotient;
  logic [DIGIT_W-1:0]    remainder;
  logic                  wr_en;
  logic                  rd_en;
  logic [DIGIT_W-1:0]    rd_digit;
  logic [RADIX_W-1:0]    in_radix;
  logic [CW-1:0]         cnt_dec;
  logic                  in_fire;
  logic                  out_fire;

  assign in_radix = s_axis_tdata_i[VALUE_W +: RADIX_W];
  assign cnt_dec  = cnt_q - CW'(1);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  u2ra_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (s_axis_tdata_i[VALUE_BITS-1:0]),
    .divisor_i  (in_radix),
    .done_o     (div_done),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  u2ra_digit_stack #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit_stack (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(cnt_q[AW-1:0]),
    .wr_data_i(remainder),
    .rd_en_i  (rd_en),
    .rd_addr_i(cnt_dec[AW-1:0]),
    .rd_data_o(rd_digit)
  );

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    bad_d         = bad_q;
    last_d        = last_q;
    div_ctrl.load = 1'b0;
    div_ctrl.next = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (in_radix < RADIX_MIN || in_radix > RADIX_MAX) begin
            bad_d   = 1'b1;
            last_d  = 1'b1;
            state_d = ST_SEND;
          end else begin
            bad_d         = 1'b0;
            cnt_d         = '0;
            div_ctrl.load = 1'b1;
            state_d       = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
          if (quotient == '0) begin
            state_d = ST_READ;
          end else begin
            div_ctrl.next = 1'b1;
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        last_d  = (cnt_q == CW'(1));
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (m_axis_tready_i) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_dec;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
      last_q  <= last_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_SEND);
  assign m_axis_tdata_o  = bad_q ? '0 : OUT_TDATA_W'(digit_to_char(rd_digit));
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = bad_q;

  // an error transaction always closes its run
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("error transaction without tlast");

  // a bad base is reported in the very next cycle
  a_bad_radix_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_radix < RADIX_MIN || in_radix > RADIX_MAX)
    |=> m_axis_tvalid_o && m_axis_tuser_o)
    else $error("bad radix not reported");

  // digit characters stay inside '0'..'9' and 'A'..'Z'
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o
    |-> (m_axis_tdata_o >= OUT_TDATA_W'(48) && m_axis_tdata_o <= OUT_TDATA_W'(57)) ||
        (m_axis_tdata_o >= OUT_TDATA_W'(65) && m_axis_tdata_o <= OUT_TDATA_W'(90)))
    else $error("digit character out of range");

  // the digit count never runs past the value width
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !m_axis_tlast_o |=> cnt_q != '0 && cnt_q <= CW'(VALUE_BITS))
    else $error("digit count out of bounds");

endmodule

@@ verif/u2ra_digit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2ra_digit_checker
// predicts the ascii digit stream of the radix converter and compares it
// ----------------------------------------------------------------------------
// Watches both stream channels. Each input transaction is turned into the
// digits it must produce, most significant first, and queued; each output
// transaction is checked field by field against the oldest queued digit.
// ----------------------------------------------------------------------------
module u2ra_digit_checker
  import u2ra_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                   m_axis_tlast_i,
  input  logic                   m_axis_tuser_i,
  output int unsigned            mismatch_cnt_o,
  output int unsigned            digits_pending_o
);

  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              bad_radix;
  } digit_exp_t;

  digit_exp_t expected_digits_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  function automatic void predict_digits(input logic [VALUE_W-1:0] raw,
                                         input logic [RADIX_W-1:0] base);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] divisor;
    logic [VALUE_W-1:0] d;
    logic [CHAR_W-1:0]  rev [64];
    digit_exp_t         e;
    int                 n;
    rest = raw & VALUE_MASK;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      e.digit_char = '0;
      e.last_digit = 1'b1;
      e.bad_radix  = 1'b1;
      expected_digits_q.push_back(e);
      return;
    end
    divisor = VALUE_W'(base);
    n = 0;
    do begin
      d = rest % divisor;
      if (d < VALUE_W'(DIGIT_LIMIT)) begin
        rev[n] = CHAR_W'(d) + CHAR_ZERO;
      end else begin
        rev[n] = CHAR_W'(d - VALUE_W'(DIGIT_LIMIT)) + CHAR_LETTER_A;
      end
      n++;
      rest = rest / divisor;
    end while (rest != 0 && n < 64);
    for (int k = 0; k < n; k++) begin
      e.digit_char = rev[n-1-k];
      e.last_digit = (k == n - 1);
      e.bad_radix  = 1'b0;
      expected_digits_q.push_back(e);
    end
  endfunction

  always @(posedge clk_i) begin
    digit_exp_t want;
    if (!rst_ni) begin
      mismatch_cnt_o = 0;
      digits_pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_digits_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, tdata %0h tlast %0b tuser %0b",
                                    m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i));
        end else begin
          want = expected_digits_q.pop_front();
          if (m_axis_tdata_i[CHAR_W-1:0] !== want.digit_char) begin
            report_mismatch($sformatf("digit_char got %0h expected %0h",
                                      m_axis_tdata_i[CHAR_W-1:0], want.digit_char));
          end
          if (m_axis_tlast_i !== want.last_digit) begin
            report_mismatch($sformatf("last_digit got %0b expected %0b",
                                      m_axis_tlast_i, want.last_digit));
          end
          if (m_axis_tuser_i !== want.bad_radix) begin
            report_mismatch($sformatf("bad_radix got %0b expected %0b",
                                      m_axis_tuser_i, want.bad_radix));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_digits(s_axis_tdata_i[VALUE_W-1:0], s_axis_tdata_i[VALUE_W +: RADIX_W]);
      end
      digits_pending_o <= expected_digits_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the unsigned to radix ascii converter
// ----------------------------------------------------------------------------
// Sends directed values and bases (zero, all ones, digit boundaries, bases
// out of range) and then random ones in bursts, while the output side stalls
// on its own pattern and once holds off long enough to back up the input.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import u2ra_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned HOLD_CYCLES  = 6000;
  localparam int unsigned TAIL_CYCLES  = 4400;
  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   hold_off;

  int unsigned mismatch_cnt;
  int unsigned digits_pending;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned rx_left    = 0;
  int unsigned rx_mode    = 0;
  bit          tx_idle    = 1'b1;
  logic [VALUE_W-1:0] rnd_value;
  logic [RADIX_W-1:0] rnd_radix;

  unsigned_to_radix_ascii #(
    .VALUE_BITS(VALUE_BITS_DEF)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tuser_o (m_tuser)
  );

  u2ra_digit_checker #(
    .VALUE_BITS(VALUE_BITS_DEF)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .m_axis_tuser_i  (m_tuser),
    .mismatch_cnt_o  (mismatch_cnt),
    .digits_pending_o(digits_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // output side stall pattern
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       m_tready <= !hold_off;
        1:       m_tready <= !hold_off && ($urandom_range(0, 1) == 0);
        default: m_tready <= !hold_off && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // long hold-off so the block backs up its input
  initial begin
    hold_off <= 1'b0;
    wait (items_sent >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic push_number(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix);
    int unsigned gap;
    s_tdata  <= {{(IN_TDATA_W-VALUE_W-RADIX_W){1'b0}}, radix, value};
    s_tvalid <= 1'b1;
    tx_idle = 1'b0;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      tx_idle = 1'b1;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_number('0, RADIX_W'(10));
    push_number('0, RADIX_MIN);
    push_number(ALL_ONES, RADIX_MIN);
    push_number(ALL_ONES, RADIX_W'(16));
    push_number(ALL_ONES, RADIX_MAX);
    push_number(ALL_ONES, RADIX_W'(10));
    push_number(ALL_ONES, RADIX_W'(3));
    push_number(VALUE_W'(1), RADIX_MIN);
    push_number(VALUE_W'(35), RADIX_MAX);
    push_number(VALUE_W'(36), RADIX_MAX);
    push_number(VALUE_W'(9), RADIX_W'(10));
    push_number(VALUE_W'(10), RADIX_W'(16));
    push_number(VALUE_W'(255), RADIX_W'(16));
    push_number('0, RADIX_MAX);
    push_number(64'h8000_0000_0000_0000, RADIX_MIN);
    push_number(64'h5555_5555_5555_5555, RADIX_W'(4));
    push_number(64'hAAAA_AAAA_AAAA_AAAA, RADIX_W'(8));
    // bases out of range
    push_number('0, RADIX_W'(0));
    push_number(VALUE_W'(12345), RADIX_W'(1));
    push_number(ALL_ONES, RADIX_W'(37));
    push_number(64'h0123_4567_89AB_CDEF, RADIX_W'(63));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        rnd_radix = ($urandom_range(0, 2) == 0) ? RADIX_W'($urandom_range(0, 1))
                                                 : RADIX_W'($urandom_range(37, 63));
      end else begin
        rnd_radix = RADIX_W'($urandom_range(2, 36));
      end
      rnd_value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0:       ;
        1:       rnd_value = rnd_value >> $urandom_range(1, 63);
        2:       rnd_value = VALUE_W'($urandom_range(0, 40));
        default: rnd_value = ALL_ONES >> $urandom_range(0, 63);
      endcase
      push_number(rnd_value, rnd_radix);
    end
    if (!tx_idle) s_tvalid <= 1'b0;

    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
